@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked while out of reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

@@ hw/rtl/tasc_pkg.sv @@
// ----------------------------------------------------------------------------
// tasc_pkg
// Types, constants and decode functions of the two-axis step controller.
// ----------------------------------------------------------------------------
package tasc_pkg;

  localparam int CNT_W     = 16;
  localparam int REG_W     = 16;
  localparam int CMP_W     = (CNT_W > REG_W) ? CNT_W : REG_W;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT     = 2'd2;

  localparam logic [REG_W-1:0] SLOW_PERIOD_RST = 16'd20;
  localparam logic [REG_W-1:0] FAST_PERIOD_RST = 16'd10;
  localparam logic [REG_W-1:0] TIMEOUT_RST     = 16'd150;

  localparam int FAST_BIT = 4;

  localparam logic [3:0] D_STOP         = 4'd0;
  localparam logic [3:0] D_TOP          = 4'd1;
  localparam logic [3:0] D_TOP_RIGHT    = 4'd2;
  localparam logic [3:0] D_RIGHT        = 4'd3;
  localparam logic [3:0] D_BOTTOM_RIGHT = 4'd4;
  localparam logic [3:0] D_BOTTOM       = 4'd5;
  localparam logic [3:0] D_BOTTOM_LEFT  = 4'd6;
  localparam logic [3:0] D_LEFT         = 4'd7;
  localparam logic [3:0] D_TOP_LEFT     = 4'd8;

  localparam logic OP_TICK = 1'b0;
  localparam logic OP_CMD  = 1'b1;

  typedef struct packed {
    logic       op;
    logic [7:0] cmd_byte;
    logic       limit_left;
    logic       limit_right;
    logic       limit_top;
    logic       limit_bottom;
  } in_item_t;

  typedef struct packed {
    logic step0;
    logic step1;
    logic dir_pin0;
    logic dir_pin1;
    logic enabled0;
    logic enabled1;
  } out_item_t;

  typedef struct packed {
    logic [REG_W-1:0] slow_period;
    logic [REG_W-1:0] fast_period;
    logic [REG_W-1:0] command_timeout;
  } cfg_t;

  // motor enable/dir pair per direction code
  typedef struct packed {
    logic en0;
    logic dir0;
    logic en1;
    logic dir1;
  } mode_t;

  function automatic logic [3:0] limit_reduce(input logic [3:0] d_in, input logic l,
                                              input logic r, input logic t,
                                              input logic b);
    logic [3:0] d;
    d = d_in;
    if (l) begin
      if (d == D_LEFT) d = D_STOP;
      else if (d == D_BOTTOM_LEFT) d = D_BOTTOM;
      else if (d == D_TOP_LEFT) d = D_TOP;
    end
    if (r) begin
      if (d == D_RIGHT) d = D_STOP;
      else if (d == D_BOTTOM_RIGHT) d = D_BOTTOM;
      else if (d == D_TOP_RIGHT) d = D_TOP;
    end
    if (t) begin
      if (d == D_TOP) d = D_STOP;
      else if (d == D_TOP_LEFT) d = D_LEFT;
      else if (d == D_TOP_RIGHT) d = D_RIGHT;
    end
    if (b) begin
      if (d == D_BOTTOM) d = D_STOP;
      else if (d == D_BOTTOM_LEFT) d = D_LEFT;
      else if (d == D_BOTTOM_RIGHT) d = D_RIGHT;
    end
    return d;
  endfunction

  function automatic mode_t mode_lookup(input logic [3:0] d);
    mode_t m;
    case (d)
      D_TOP:          m = 4'b1110;
      D_TOP_RIGHT:    m = 4'b0010;
      D_RIGHT:        m = 4'b1010;
      D_BOTTOM_RIGHT: m = 4'b1000;
      D_BOTTOM:       m = 4'b1011;
      D_BOTTOM_LEFT:  m = 4'b0011;
      D_LEFT:         m = 4'b1111;
      D_TOP_LEFT:     m = 4'b1100;
      default:        m = 4'b0000;
    endcase
    return m;
  endfunction

endpackage

@@ hw/rtl/tasc_cfg.sv @@
// ----------------------------------------------------------------------------
// tasc_cfg
// Period and timeout registers behind the write-only configuration port.
// ----------------------------------------------------------------------------
module tasc_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [tasc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [tasc_pkg::REG_W-1:0]        cfg_wdata,
  output tasc_pkg::cfg_t                    cfg
);

  tasc_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slow_period     <= tasc_pkg::SLOW_PERIOD_RST;
      cfg_r.fast_period     <= tasc_pkg::FAST_PERIOD_RST;
      cfg_r.command_timeout <= tasc_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        tasc_pkg::CFG_SLOW_PERIOD: cfg_r.slow_period     <= cfg_wdata;
        tasc_pkg::CFG_FAST_PERIOD: cfg_r.fast_period     <= cfg_wdata;
        tasc_pkg::CFG_TIMEOUT:     cfg_r.command_timeout <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ hw/rtl/tasc_core.sv @@
// ----------------------------------------------------------------------------
// tasc_core
// Motor state and the per-beat update: pulse counter, timeout, command decode.
// ----------------------------------------------------------------------------
module tasc_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  tasc_pkg::in_item_t   item,
  input  tasc_pkg::cfg_t       cfg,
  output tasc_pkg::out_item_t  res
);

  logic [tasc_pkg::CNT_W-1:0] pulse_r, pulse_nxt;
  logic [tasc_pkg::CNT_W-1:0] expire_r, expire_nxt;
  logic                       fast_r, fast_nxt;
  logic [1:0]                 en_r, en_nxt;
  logic [1:0]                 dir_r, dir_nxt;
  logic [1:0]                 pin_r, pin_nxt;

  logic [tasc_pkg::CNT_W-1:0] cnt_inc;
  logic [tasc_pkg::REG_W-1:0] period;
  logic                       hit;
  logic [1:0]                 step;
  logic [3:0]                 dcode;
  tasc_pkg::mode_t            mode;

  always_comb begin
    period  = fast_r ? cfg.fast_period : cfg.slow_period;
    cnt_inc = pulse_r + 1'b1;
    hit     = tasc_pkg::CMP_W'(cnt_inc) >= tasc_pkg::CMP_W'(period);
    dcode   = tasc_pkg::limit_reduce(item.cmd_byte[3:0], item.limit_left,
                                     item.limit_right, item.limit_top,
                                     item.limit_bottom);
    mode    = tasc_pkg::mode_lookup(dcode);

    pulse_nxt  = pulse_r;
    expire_nxt = expire_r;
    fast_nxt   = fast_r;
    en_nxt     = en_r;
    dir_nxt    = dir_r;
    pin_nxt    = pin_r;
    step       = 2'b00;

    if (item.op == tasc_pkg::OP_TICK) begin
      pulse_nxt = hit ? '0 : cnt_inc;
      step      = hit ? en_r : 2'b00;
      for (int m = 0; m < 2; m++) begin
        if (step[m]) pin_nxt[m] = dir_r[m];
      end
      if (expire_r != '0) begin
        expire_nxt = expire_r - 1'b1;
      end else begin
        en_nxt = 2'b00;
      end
    end else begin
      expire_nxt = tasc_pkg::CNT_W'(cfg.command_timeout);
      fast_nxt   = item.cmd_byte[tasc_pkg::FAST_BIT];
      if (dcode == tasc_pkg::D_STOP) begin
        en_nxt = 2'b00;
      end else if (dcode <= tasc_pkg::D_TOP_LEFT) begin
        en_nxt  = {mode.en1, mode.en0};
        dir_nxt = {mode.dir1, mode.dir0};
      end
    end

    res.step0    = step[0];
    res.step1    = step[1];
    res.dir_pin0 = pin_nxt[0];
    res.dir_pin1 = pin_nxt[1];
    res.enabled0 = en_nxt[0];
    res.enabled1 = en_nxt[1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_r  <= '0;
      expire_r <= '0;
      fast_r   <= 1'b0;
      en_r     <= 2'b00;
      dir_r    <= 2'b00;
      pin_r    <= 2'b00;
    end else if (fire) begin
      pulse_r  <= pulse_nxt;
      expire_r <= expire_nxt;
      fast_r   <= fast_nxt;
      en_r     <= en_nxt;
      dir_r    <= dir_nxt;
      pin_r    <= pin_nxt;
    end
  end

endmodule

@@ hw/rtl/two_axis_step_command_controller.sv @@
// Path: an accepted input beat is held in the input register, then its result beat in the result register.
// Throughput: one beat per cycle; a beat leaves the input register whenever
// the result register is empty or being taken in the same cycle.
// Reset: synchronous active-low rst_n empties both registers, clears counters
// and motor state, and loads the period/timeout registers with 20, 10, 150.
// ----------------------------------------------------------------------------
// two_axis_step_command_controller
// Step/direction controller for two motors: tick and command beats in,
// one step/direction/enable result beat out per input beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module two_axis_step_command_controller (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tasc_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tasc_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [tasc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tasc_pkg::REG_W-1:0]      cfg_wdata
);

  tasc_pkg::in_item_t  in_data_r;
  logic                in_valid_r;
  tasc_pkg::out_item_t out_data_r;
  logic                out_valid_r;
  tasc_pkg::cfg_t      cfg;
  tasc_pkg::out_item_t res;
  logic                out_free;
  logic                fire;
  logic                in_take;

  assign out_free = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_free;
  assign in_stall = in_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  tasc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tasc_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) in_data_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_CLK(a_stall_only_when_full, clk, rst_n, in_stall |-> (in_valid_r && out_valid_r && out_stall), "input stalled while a register has room")
  `ASSERT_CLK(a_fire_fills_output, clk, rst_n, fire |=> out_valid_r, "processed beat did not reach the result register")
  `ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> (!in_valid_r && !out_valid_r), "registers not empty after reset")

endmodule
